[rtl/core/bvn_pkg.sv]
// Shared constants, field widths and sideband types for the B-spline value noise unit.
// No dependencies; all other files but bvn_ram import this package.
package bvn_pkg;

  localparam int TABLE_WIDTH_DEF = 50;

  localparam int RANGE_W  = 12;
  localparam int COORD_W  = 24;
  localparam int FRAC_W   = 16;
  localparam int VAL_W    = 17;
  localparam int IDX_W    = 12;
  localparam int SCALED_W = COORD_W + RANGE_W;
  localparam int CELL_W   = SCALED_W - FRAC_W;

  // weights are exact in Q0.33
  localparam int W_W       = 2 * FRAC_W + 1;
  localparam int ROW_SHIFT = 19;
  localparam int OUT_SHIFT = 47;

  // restoring divide by range, two stages of reciprocal mod by table width, neighbor select
  localparam int WRAP_LAT  = CELL_W + 3;
  localparam int BLEND_LAT = 6;

  localparam logic [VAL_W-1:0] ONE_Q16 = VAL_W'(65536);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_t;

  typedef struct packed {
    logic             valid;
    op_t              op;
    logic [IDX_W-1:0] wr_idx;
    logic [VAL_W-1:0] wr_val;
  } side_t;

endpackage

[rtl/core/bvn_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module bvn_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 2500
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/bvn_wrap.sv]
// One axis: cell mod range (bit-serial restoring pipeline), mod table width by
// reciprocal multiply, then the three wrapped neighbor indices. Depends on bvn_pkg.
module bvn_wrap #(
  parameter int TABLE_WIDTH = bvn_pkg::TABLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [bvn_pkg::RANGE_W-1:0]         range,
  input  logic [bvn_pkg::CELL_W-1:0]          cell_in,
  input  logic [bvn_pkg::FRAC_W-1:0]          u,
  output logic [$clog2(TABLE_WIDTH)-1:0]      idx [3],
  output logic [bvn_pkg::FRAC_W-1:0]          u_out
);
  import bvn_pkg::*;

  localparam int IXW = $clog2(TABLE_WIDTH);
  // quotient by table width is exact for any 12-bit value with this shift and multiplier
  localparam int RS  = RANGE_W + IXW;
  localparam int PW  = RANGE_W + RS;
  localparam logic [RS-1:0] RECIP =
    RS'(((64'd1 << RS) + 64'(TABLE_WIDTH) - 64'd1) / 64'(TABLE_WIDTH));

  typedef struct packed {
    logic [CELL_W-1:0]  cval;
    logic [RANGE_W-1:0] rem;
    logic [FRAC_W-1:0]  u;
  } div_t;

  typedef struct packed {
    logic [RANGE_W-1:0] c;
    logic [RANGE_W-1:0] q;
    logic [FRAC_W-1:0]  u;
  } quo_t;

  typedef struct packed {
    logic [RANGE_W-1:0] c;
    logic [IXW-1:0]     r;
    logic [FRAC_W-1:0]  u;
  } mod_t;

  function automatic logic [RANGE_W-1:0] div_step(input logic [RANGE_W-1:0] rem,
                                                  input logic din,
                                                  input logic [RANGE_W-1:0] d);
    logic [RANGE_W:0] t;
    t = {rem, din};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[RANGE_W-1:0];
  endfunction

  div_t div_r [CELL_W];
  quo_t quo_r;
  mod_t mod_r;

  for (genvar k = 0; k < CELL_W; k++) begin : g_div
    div_t src;
    if (k == 0) begin : g_first
      assign src = {cell_in, {RANGE_W{1'b0}}, u};
    end else begin : g_next
      assign src = div_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        div_r[k].cval <= src.cval;
        div_r[k].rem  <= div_step(src.rem, src.cval[CELL_W-1-k], range);
        div_r[k].u    <= src.u;
      end
    end
  end

  logic [PW-1:0]      quo_prod;
  logic [RANGE_W-1:0] quo_back;

  always_comb begin
    quo_prod = PW'(div_r[CELL_W-1].rem) * PW'(RECIP);
    quo_back = RANGE_W'(quo_r.q * RANGE_W'(TABLE_WIDTH));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r.c <= div_r[CELL_W-1].rem;
      quo_r.q <= quo_prod[RS +: RANGE_W];
      quo_r.u <= div_r[CELL_W-1].u;
      mod_r.c <= quo_r.c;
      mod_r.r <= IXW'(quo_r.c - quo_back);
      mod_r.u <= quo_r.u;
    end
  end

  // neighbor select: cell, cell+1, cell+2 each wrapped by range, then by table width
  mod_t             m;
  logic [RANGE_W:0] c1, c2;
  logic [RANGE_W-1:0] c1w, c2w;
  logic             wrap1, wrap2, big;
  logic [IXW:0]     r1, t2s;
  logic [IXW-1:0]   t1, t2;
  logic [IXW-1:0]   idx_nxt [3];
  logic [IXW-1:0]   idx_r [3];
  logic [FRAC_W-1:0] u_r;

  always_comb begin
    m     = mod_r;
    c1    = {1'b0, m.c} + 1'b1;
    wrap1 = (c1 == {1'b0, range});
    c1w   = wrap1 ? '0 : c1[RANGE_W-1:0];
    c2    = {1'b0, c1w} + 1'b1;
    wrap2 = (c2 == {1'b0, range});
    c2w   = wrap2 ? '0 : c2[RANGE_W-1:0];
    big   = (range > RANGE_W'(TABLE_WIDTH));
    r1    = {1'b0, m.r} + 1'b1;
    t1    = (wrap1 || r1 == (IXW+1)'(TABLE_WIDTH)) ? '0 : r1[IXW-1:0];
    t2s   = {1'b0, t1} + 1'b1;
    t2    = (wrap2 || t2s == (IXW+1)'(TABLE_WIDTH)) ? '0 : t2s[IXW-1:0];
    if (big) begin
      idx_nxt[0] = m.r;
      idx_nxt[1] = t1;
      idx_nxt[2] = t2;
    end else begin
      idx_nxt[0] = m.c[IXW-1:0];
      idx_nxt[1] = c1w[IXW-1:0];
      idx_nxt[2] = c2w[IXW-1:0];
    end
    // a range of one pins the third neighbor to index 1
    if (range == RANGE_W'(1)) begin
      idx_nxt[2] = IXW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r <= idx_nxt;
      u_r   <= m.u;
    end
  end

  assign idx   = idx_r;
  assign u_out = u_r;

endmodule

[rtl/core/bvn_blend.sv]
// Quadratic B-spline weights and the 3x3 weighted sum, six register stages.
// Depends on bvn_pkg. Impulse data arrives in the cycle after the fractions.
module bvn_blend (
  input  logic                       clk,
  input  logic                       en,
  input  logic [bvn_pkg::FRAC_W-1:0] ux,
  input  logic [bvn_pkg::FRAC_W-1:0] uy,
  input  logic [bvn_pkg::VAL_W-1:0]  pval [9],
  output logic [bvn_pkg::VAL_W-1:0]  noise
);
  import bvn_pkg::*;

  localparam int PROD_W = W_W + VAL_W;
  localparam int ROW_W  = PROD_W - ROW_SHIFT;
  localparam int YP_W   = W_W + ROW_W;

  function automatic logic [W_W-1:0] w_lo(input logic [FRAC_W-1:0] u);
    logic [FRAC_W:0]   a;
    logic [W_W:0]      sq;
    a  = ONE_Q16 - {1'b0, u};
    sq = (W_W+1)'(a) * (W_W+1)'(a);
    return sq[W_W-1:0];
  endfunction

  function automatic logic [W_W-1:0] w_hi(input logic [FRAC_W-1:0] u);
    logic [2*FRAC_W-1:0] sq;
    sq = u * u;
    return W_W'(sq);
  endfunction

  function automatic logic [W_W-1:0] w_mid(input logic [W_W-1:0] w0, input logic [W_W-1:0] w2);
    logic [W_W:0] t;
    t = {1'b1, {W_W{1'b0}}} - {1'b0, w0} - {1'b0, w2};
    return t[W_W-1:0];
  endfunction

  logic [W_W-1:0]    sx0_r, sx2_r, sy0_r, sy2_r;
  logic [W_W-1:0]    wx_r [3];
  logic [W_W-1:0]    wy_r [3];
  logic [W_W-1:0]    wy_d1_r [3];
  logic [W_W-1:0]    wy_d2_r [3];
  logic [VAL_W-1:0]  p_r [9];
  logic [PROD_W-1:0] prod_r [9];
  logic [ROW_W-1:0]  row_nxt [3];
  logic [ROW_W-1:0]  row_r [3];
  logic [YP_W-1:0]   yp_r [3];
  logic [VAL_W-1:0]  noise_nxt;
  logic [VAL_W-1:0]  noise_r;

  always_comb begin
    logic [PROD_W+1:0] s;
    logic [YP_W+1:0]   tot;
    for (int j = 0; j < 3; j++) begin
      s = (PROD_W+2)'(prod_r[3*j]) + (PROD_W+2)'(prod_r[3*j+1])
        + (PROD_W+2)'(prod_r[3*j+2]);
      row_nxt[j] = s[ROW_SHIFT +: ROW_W];
    end
    tot = (YP_W+2)'(yp_r[0]) + (YP_W+2)'(yp_r[1]) + (YP_W+2)'(yp_r[2]);
    noise_nxt = tot[OUT_SHIFT +: VAL_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx0_r <= w_lo(ux);
      sx2_r <= w_hi(ux);
      sy0_r <= w_lo(uy);
      sy2_r <= w_hi(uy);

      wx_r[0] <= sx0_r;
      wx_r[1] <= w_mid(sx0_r, sx2_r);
      wx_r[2] <= sx2_r;
      wy_r[0] <= sy0_r;
      wy_r[1] <= w_mid(sy0_r, sy2_r);
      wy_r[2] <= sy2_r;
      p_r     <= pval;

      for (int k = 0; k < 9; k++) begin
        prod_r[k] <= PROD_W'(wx_r[k % 3]) * PROD_W'(p_r[k]);
      end
      wy_d1_r <= wy_r;

      row_r   <= row_nxt;
      wy_d2_r <= wy_d1_r;

      for (int j = 0; j < 3; j++) begin
        yp_r[j] <= YP_W'(wy_d2_r[j]) * YP_W'(row_r[j]);
      end

      noise_r <= noise_nxt;
    end
  end

  assign noise = noise_r;

endmodule

[rtl/core/bspline_value_noise_2d_unit.sv]
// Top level of the tileable 2D value noise unit with quadratic B-spline smoothing.
// Depends on bvn_pkg, bvn_ram, bvn_wrap and bvn_blend.
//
//   channel | direction | handshake              | payload
//   cfg     | in        | cfg_valid / cfg_ready  | cfg_sample_range
//   in      | in        | in_valid / in_ready    | opcode, table index/value, x, y
//   out     | out       | out_valid / out_ready  | out_noise_value
//
// One request per cycle while the pipe is not stalled. After an entry stage that scales
// the coordinates, a request passes one stage per cell bit for the remainder by range,
// two for the table-width wrap, one for neighbor select, then six in the blend.
// Nine table copies give the 3x3 reads in the same cycle; table writes are applied at the
// read stage so they stay ordered with evaluates. The whole pipe stalls only while a
// result waits at the output and out_ready is low. Reset is synchronous and clears the
// valid bits and the range register; the table is not cleared.
module bspline_value_noise_2d_unit #(
  parameter int TABLE_WIDTH = bvn_pkg::TABLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bvn_pkg::RANGE_W-1:0]   cfg_sample_range,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [bvn_pkg::IDX_W-1:0]     in_table_index,
  input  logic [bvn_pkg::VAL_W-1:0]     in_table_value,
  input  logic [bvn_pkg::COORD_W-1:0]   in_x_coord,
  input  logic [bvn_pkg::COORD_W-1:0]   in_y_coord,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bvn_pkg::VAL_W-1:0]     out_noise_value
);
  import bvn_pkg::*;

  localparam int DEPTH = TABLE_WIDTH * TABLE_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int IXW   = $clog2(TABLE_WIDTH);
  localparam int LAST  = WRAP_LAT + BLEND_LAT;

  logic [RANGE_W-1:0]  sample_range_r;
  logic                adv;
  side_t               side_r [LAST+1];
  side_t               side_a;
  logic [SCALED_W-1:0] sx_r, sy_r;
  logic [IXW-1:0]      ix [3];
  logic [IXW-1:0]      iy [3];
  logic [FRAC_W-1:0]   ux_a, uy_a;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [VAL_W-1:0]    pval [9];
  logic [VAL_W-1:0]    noise;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_range_r <= '0;
    end else if (cfg_valid) begin
      sample_range_r <= cfg_sample_range;
    end
  end

  // entry stage: scale coordinates, saturate write data
  always_ff @(posedge clk) begin
    if (adv) begin
      sx_r <= SCALED_W'(in_x_coord) * SCALED_W'(sample_range_r);
      sy_r <= SCALED_W'(in_y_coord) * SCALED_W'(sample_range_r);
    end
  end

  for (genvar k = 0; k <= LAST; k++) begin : g_side
    side_t src;
    if (k == 0) begin : g_first
      assign src = {in_valid, op_t'(in_opcode), in_table_index,
                    (in_table_value > ONE_Q16) ? ONE_Q16 : in_table_value};
    end else begin : g_next
      assign src = side_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[k].valid <= 1'b0;
      end else if (adv) begin
        side_r[k] <= src;
      end
    end
  end

  bvn_wrap #(.TABLE_WIDTH(TABLE_WIDTH)) u_wrap_x (
    .clk     (clk),
    .en      (adv),
    .range   (sample_range_r),
    .cell_in (sx_r[SCALED_W-1:FRAC_W]),
    .u       (sx_r[FRAC_W-1:0]),
    .idx     (ix),
    .u_out   (ux_a)
  );

  bvn_wrap #(.TABLE_WIDTH(TABLE_WIDTH)) u_wrap_y (
    .clk     (clk),
    .en      (adv),
    .range   (sample_range_r),
    .cell_in (sy_r[SCALED_W-1:FRAC_W]),
    .u       (sy_r[FRAC_W-1:0]),
    .idx     (iy),
    .u_out   (uy_a)
  );

  // table access stage
  assign side_a  = side_r[WRAP_LAT];
  assign wr_en   = adv && side_a.valid && side_a.op == OP_WRITE
                   && ({{(32-IDX_W){1'b0}}, side_a.wr_idx} < 32'(DEPTH));
  assign wr_addr = AW'(side_a.wr_idx);

  for (genvar j = 0; j < 3; j++) begin : g_row
    for (genvar i = 0; i < 3; i++) begin : g_col
      logic [AW-1:0] rd_addr;
      assign rd_addr = AW'(AW'(iy[j]) * AW'(TABLE_WIDTH)) + AW'(ix[i]);
      bvn_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_tbl (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (side_a.wr_val),
        .rd_en   (adv),
        .rd_addr (rd_addr),
        .rd_data (pval[3*j+i])
      );
    end
  end

  bvn_blend u_blend (
    .clk   (clk),
    .en    (adv),
    .ux    (ux_a),
    .uy    (uy_a),
    .pval  (pval),
    .noise (noise)
  );

  assign out_valid       = side_r[LAST].valid && side_r[LAST].op == OP_EVAL;
  assign out_noise_value = (sample_range_r == '0) ? '0 : noise;

endmodule

[rtl/core/bvn_chk.sv]
// Port-level checker for the value noise unit, bound to the top level.
// Depends on bvn_pkg.
module bvn_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [bvn_pkg::RANGE_W-1:0] cfg_sample_range,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bvn_pkg::VAL_W-1:0]   out_noise_value
);
  import bvn_pkg::*;

  logic [RANGE_W-1:0] range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      range_r <= cfg_sample_range;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_noise_value))
    else $error("result changed while stalled");

  a_out_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_noise_value <= ONE_Q16)
    else $error("noise value above one");

  a_zero_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && range_r == '0 |-> out_noise_value == '0)
    else $error("nonzero result with range zero");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bspline_value_noise_2d_unit bvn_chk u_chk (.*);
